@@ hw/rtl/fsmc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Frame slot metadata checker package
// Shared field widths, function codes, states and entry/result structures.
// ----------------------------------------------------------------------------
package fsmc_pkg;

    localparam int PULSE_W    = 64;
    localparam int FRAME_W    = 64;
    localparam int RECORD_W   = 32;
    localparam int PACKETS_W  = 8;
    localparam int MODULE_W   = 5;
    localparam int SLOTS_W    = 5;
    localparam int MODULES_W  = 6;
    localparam int NUM_MOD_W  = 7;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = PULSE_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 2'd2;

    localparam logic [SLOTS_W-1:0]   SLOTS_RESET    = 5'd16;
    localparam logic [MODULES_W-1:0] MODULES_RESET  = 6'd32;
    localparam logic [PACKETS_W-1:0] EXPECTED_RESET = 8'd128;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE    = 2'd0,
        FN_READ     = 2'd1,
        FN_ASSEMBLE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ACCESS,
        ST_READ,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse_num;
        logic [FRAME_W-1:0]   frame_num;
        logic [RECORD_W-1:0]  acq_record;
        logic [PACKETS_W-1:0] packet_count;
    } t_entry;

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse_num;
        logic [FRAME_W-1:0]   frame_num;
        logic [RECORD_W-1:0]  acq_record;
        logic [PACKETS_W-1:0] packet_count;
        logic                 image_good;
        logic                 outcome;
    } t_result;

endpackage
`default_nettype wire

@@ hw/rtl/frame_slot_metadata_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Frame slot metadata checker
// Ring store of per-module frame metadata with read-back and image assembly.
// ----------------------------------------------------------------------------
// Items enter on the input channel (i_in_valid, o_in_stall) and results leave
// on the output channel (o_out_valid, i_out_stall). A write item gives no
// result; a read or assemble item gives one. The three settings registers are
// written through i_cfg_valid/o_cfg_ready; the user is to write them only
// while the block is idle, which the block itself does not enforce.
// One item is worked on at a time. The slot is found by an iterative
// remainder unit that folds eight pulse id bits per cycle. A write returns
// the block to idle as its entry is written, and the next item can then be
// accepted. A read takes its result from the addressed entry; an assemble
// walks the modules in use in the slot, reading one module entry per cycle
// through the single memory port. The block returns to idle, and so can take
// the next item, as a result is loaded into the output register.
// After reset the block clears the packet counts of all
// MAX_SLOTS * MAX_MODULES entries, one per cycle, with o_in_stall high;
// settings writes are taken during that time.
// A finished result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile and holds its own result until the
// output register is free.
// ----------------------------------------------------------------------------
module frame_slot_metadata_checker #(
    parameter int MAX_SLOTS   = 16,
    parameter int MAX_MODULES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fsmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [fsmc_pkg::FUNC_W-1:0]      i_func,
    input  logic [fsmc_pkg::PULSE_W-1:0]     i_pulse_num,
    input  logic [fsmc_pkg::MODULE_W-1:0]    i_module_id,
    input  logic [fsmc_pkg::PACKETS_W-1:0]   i_packet_count,
    input  logic [fsmc_pkg::FRAME_W-1:0]     i_frame_num,
    input  logic [fsmc_pkg::RECORD_W-1:0]    i_acq_record,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fsmc_pkg::PULSE_W-1:0]     o_out_pulse_num,
    output logic [fsmc_pkg::FRAME_W-1:0]     o_out_frame_num,
    output logic [fsmc_pkg::RECORD_W-1:0]    o_out_acq_record,
    output logic [fsmc_pkg::PACKETS_W-1:0]   o_out_packet_count,
    output logic                             o_image_good,
    output logic                             o_outcome
);
    import fsmc_pkg::*;

    localparam int DEPTH  = MAX_SLOTS * MAX_MODULES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SLOTS_W-1:0]   r_slots;
    logic [MODULES_W-1:0] r_modules;
    logic [PACKETS_W-1:0] r_expected;

    logic [SLOTS_W-1:0]   w_eff_slots;
    logic [NUM_MOD_W-1:0] w_num_modules;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [SLOTS_W-1:0]   w_div_rem;
    logic                 w_mem_en;
    logic                 w_mem_we;
    logic [ADDR_W-1:0]    w_mem_addr;
    t_entry               w_mem_wdata;
    t_entry               w_mem_rdata;
    t_result              w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots    <= SLOTS_RESET;
            r_modules  <= MODULES_RESET;
            r_expected <= EXPECTED_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLOTS:    r_slots    <= i_cfg_data[SLOTS_W-1:0];
                CFG_MODULES:  r_modules  <= i_cfg_data[MODULES_W-1:0];
                CFG_EXPECTED: r_expected <= i_cfg_data[PACKETS_W-1:0];
                default:      r_expected <= r_expected;
            endcase
        end
    end

    always_comb begin
        if (r_slots == '0) begin
            w_eff_slots = SLOTS_W'(1);
        end else if (int'(r_slots) > MAX_SLOTS) begin
            w_eff_slots = SLOTS_W'(MAX_SLOTS);
        end else begin
            w_eff_slots = r_slots;
        end
        if (int'(r_modules) > MAX_MODULES) begin
            w_num_modules = NUM_MOD_W'(MAX_MODULES);
        end else begin
            w_num_modules = NUM_MOD_W'(r_modules);
        end
    end

    fsmc_slot_div u_slot_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_pulse_num),
        .i_divisor  (w_eff_slots),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    fsmc_meta_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    fsmc_ctrl #(
        .MAX_SLOTS   (MAX_SLOTS),
        .MAX_MODULES (MAX_MODULES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_pulse_num    (i_pulse_num),
        .i_module_id    (i_module_id),
        .i_packet_count (i_packet_count),
        .i_frame_num    (i_frame_num),
        .i_acq_record   (i_acq_record),
        .i_num_modules  (w_num_modules),
        .i_expected     (r_expected),
        .o_div_start    (w_div_start),
        .i_div_done     (w_div_done),
        .i_div_rem      (w_div_rem),
        .o_mem_en       (w_mem_en),
        .o_mem_we       (w_mem_we),
        .o_mem_addr     (w_mem_addr),
        .o_mem_wdata    (w_mem_wdata),
        .i_mem_rdata    (w_mem_rdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out          (w_out)
    );

    assign o_out_pulse_num    = w_out.pulse_num;
    assign o_out_frame_num    = w_out.frame_num;
    assign o_out_acq_record   = w_out.acq_record;
    assign o_out_packet_count = w_out.packet_count;
    assign o_image_good       = w_out.image_good;
    assign o_outcome          = w_out.outcome;

endmodule
`default_nettype wire

@@ hw/rtl/fsmc_slot_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Slot remainder unit
// Computes a 64-bit pulse id modulo the slot count, eight bits per cycle.
// ----------------------------------------------------------------------------
module fsmc_slot_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fsmc_pkg::PULSE_W-1:0]  i_dividend,
    input  logic [fsmc_pkg::SLOTS_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [fsmc_pkg::SLOTS_W-1:0]  o_rem
);
    import fsmc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PULSE_W-1:0]   r_shift;
    logic [SLOTS_W-1:0]   r_rem;
    logic [SLOTS_W-1:0]   r_div;
    logic [SLOTS_W-1:0]   n_rem;
    logic [SLOTS_W:0]     v_t;
    logic [SLOTS_W-1:0]   v_rem;

    always_comb begin
        v_rem = r_rem;
        v_t   = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            v_t = {v_rem, r_shift[PULSE_W-1-j]};
            if (v_t >= {1'b0, r_div}) begin
                v_t = v_t - {1'b0, r_div};
            end
            v_rem = v_t[SLOTS_W-1:0];
        end
        n_rem = v_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[PULSE_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ hw/rtl/fsmc_meta_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Metadata memory
// Single-port synchronous memory of module entries with registered read data.
// ----------------------------------------------------------------------------
module fsmc_meta_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_addr,
    input  fsmc_pkg::t_entry     i_wdata,
    output fsmc_pkg::t_entry     o_rdata
);
    import fsmc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/fsmc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Metadata checker control
// Sequences clearing, writes, reads and the assemble walk over one slot,
// and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module fsmc_ctrl #(
    parameter int  MAX_SLOTS   = 16,
    parameter int  MAX_MODULES = 32,
    localparam int DEPTH       = MAX_SLOTS * MAX_MODULES,
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fsmc_pkg::FUNC_W-1:0]     i_func,
    input  logic [fsmc_pkg::PULSE_W-1:0]    i_pulse_num,
    input  logic [fsmc_pkg::MODULE_W-1:0]   i_module_id,
    input  logic [fsmc_pkg::PACKETS_W-1:0]  i_packet_count,
    input  logic [fsmc_pkg::FRAME_W-1:0]    i_frame_num,
    input  logic [fsmc_pkg::RECORD_W-1:0]   i_acq_record,
    input  logic [fsmc_pkg::NUM_MOD_W-1:0]  i_num_modules,
    input  logic [fsmc_pkg::PACKETS_W-1:0]  i_expected,
    output logic                            o_div_start,
    input  logic                            i_div_done,
    input  logic [fsmc_pkg::SLOTS_W-1:0]    i_div_rem,
    output logic                            o_mem_en,
    output logic                            o_mem_we,
    output logic [ADDR_W-1:0]               o_mem_addr,
    output fsmc_pkg::t_entry                o_mem_wdata,
    input  fsmc_pkg::t_entry                i_mem_rdata,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fsmc_pkg::t_result               o_out
);
    import fsmc_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MOD_W  = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam int NUM_IDS = 2 ** MODULE_W;

    t_state                 r_state;
    t_state                 n_state;
    logic [ADDR_W-1:0]      r_clr_addr;
    t_func                  r_func;
    logic [PULSE_W-1:0]     r_pulse;
    logic [MODULE_W-1:0]    r_module;
    logic [PACKETS_W-1:0]   r_packets;
    logic [FRAME_W-1:0]     r_frame;
    logic [RECORD_W-1:0]    r_record;
    logic [SLOT_W-1:0]      r_slot;
    logic [NUM_MOD_W-1:0]   r_idx;
    logic                   r_pend;
    logic                   r_have;
    logic                   r_good;
    logic                   r_mis;
    logic [PULSE_W-1:0]     r_id;
    logic [FRAME_W-1:0]     r_u1;
    logic [RECORD_W-1:0]    r_u2;
    t_result                r_res;
    logic                   r_out_valid;
    t_result                r_out;

    logic [MOD_W-1:0]       w_mod_tab [NUM_IDS];
    logic                   w_accept;
    logic                   w_func_ok;
    logic                   w_walk_issue;
    logic                   w_walk_end;
    logic                   w_out_free;
    logic                   w_complete;
    logic [ADDR_W-1:0]      w_slot_base;
    logic [ADDR_W-1:0]      w_item_addr;
    logic [ADDR_W-1:0]      w_walk_addr;

    for (genvar k = 0; k < NUM_IDS; k++) begin : g_mod_tab
        assign w_mod_tab[k] = MOD_W'(k % MAX_MODULES);
    end

    assign w_func_ok = (i_func == FN_WRITE) || (i_func == FN_READ) ||
                       (i_func == FN_ASSEMBLE);
    assign w_accept     = i_in_valid && (r_state == ST_IDLE);
    assign w_walk_issue = r_idx < i_num_modules;
    assign w_walk_end   = !w_walk_issue && !r_pend;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_complete   = (i_expected != '0) && (i_mem_rdata.packet_count == i_expected);
    assign w_slot_base  = ADDR_W'(ADDR_W'(r_slot) * ADDR_W'(MAX_MODULES));
    assign w_item_addr  = w_slot_base + ADDR_W'(w_mod_tab[r_module]);
    assign w_walk_addr  = w_slot_base + ADDR_W'(r_idx[MOD_W-1:0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && w_func_ok) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                case (r_func)
                    FN_READ:     n_state = ST_READ;
                    FN_ASSEMBLE: n_state = ST_WALK;
                    default:     n_state = ST_IDLE;
                endcase
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_WALK: begin
                if (w_walk_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_div_start = w_accept && w_func_ok;
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = w_item_addr;
        o_mem_wdata = '{pulse_num: r_pulse, frame_num: r_frame,
                        acq_record: r_record, packet_count: r_packets};
        case (r_state)
            ST_CLEAR: begin
                o_mem_en    = 1'b1;
                o_mem_we    = 1'b1;
                o_mem_addr  = r_clr_addr;
                o_mem_wdata = '0;
            end
            ST_ACCESS: begin
                o_mem_en = (r_func == FN_WRITE) || (r_func == FN_READ);
                o_mem_we = (r_func == FN_WRITE);
            end
            ST_WALK: begin
                o_mem_en   = w_walk_issue;
                o_mem_addr = w_walk_addr;
            end
            default: begin
                o_mem_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_func_ok) begin
            r_func    <= t_func'(i_func);
            r_pulse   <= i_pulse_num;
            r_module  <= i_module_id;
            r_packets <= i_packet_count;
            r_frame   <= i_frame_num;
            r_record  <= i_acq_record;
        end
        if ((r_state == ST_DIV) && i_div_done) begin
            r_slot <= SLOT_W'(i_div_rem);
        end
        if (r_state == ST_ACCESS) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
            r_have <= 1'b0;
            r_good <= 1'b1;
            r_mis  <= 1'b0;
            r_id   <= '0;
            r_u1   <= '0;
            r_u2   <= '0;
        end
        if (r_state == ST_READ) begin
            r_res <= '{pulse_num: i_mem_rdata.pulse_num,
                       frame_num: i_mem_rdata.frame_num,
                       acq_record: i_mem_rdata.acq_record,
                       packet_count: i_mem_rdata.packet_count,
                       image_good: 1'b0, outcome: 1'b0};
        end
        if (r_state == ST_WALK) begin
            if (w_walk_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            r_pend <= w_walk_issue;
            if (r_pend && !r_mis) begin
                if (!w_complete) begin
                    r_good <= 1'b0;
                end else if (!r_have) begin
                    if (i_mem_rdata.pulse_num != r_pulse) begin
                        r_mis <= 1'b1;
                    end else begin
                        r_have <= 1'b1;
                        r_id   <= i_mem_rdata.pulse_num;
                        r_u1   <= i_mem_rdata.frame_num;
                        r_u2   <= i_mem_rdata.acq_record;
                    end
                end else if ((i_mem_rdata.pulse_num != r_id) ||
                             (i_mem_rdata.frame_num != r_u1) ||
                             (i_mem_rdata.acq_record != r_u2)) begin
                    r_good <= 1'b0;
                end
            end
            if (w_walk_end) begin
                if (r_mis) begin
                    r_res <= '{pulse_num: '0, frame_num: '0, acq_record: '0,
                               packet_count: '0, image_good: 1'b0, outcome: 1'b1};
                end else begin
                    r_res <= '{pulse_num: r_id, frame_num: r_u1, acq_record: r_u2,
                               packet_count: '0, image_good: r_good, outcome: 1'b0};
                end
            end
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
